/* design/dbq_pkg.sv */
// package for the bounded deque with search
// types, operation and status codes shared by the dbq modules other than dbq_ram; no dependencies
`timescale 1ns / 1ps

package dbq_pkg;

    // default number of entries
    localparam int DEPTH_DEF = 16;

    // fixed field widths of the request and response
    localparam int MODE_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 5;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CONTAINS   = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [VALUE_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic                found;
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    count;
    } t_rsp;

    // status of the search unit towards the control
    typedef struct packed {
        logic busy;
        logic done;
        logic found;
    } t_scan_stat;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

endpackage

/* design/bounded_deque_with_search_core.sv */
// top level of the bounded deque with membership search
// depends on dbq_pkg, dbq_ram and dbq_scan
`timescale 1ns / 1ps

// Bounded double-ended queue of signed 32-bit values held in a circular buffer
// in one synchronous ram, with a head pointer and entry count in registers.
// Push back, push front, pop front and pop back each complete on acceptance: the
// request is accepted, the pointer and count update and at most one ram write
// happens, and the response is loaded into the output register at once.
// Contains walks every held entry through the single ram read port, one entry
// per cycle, and holds the block until the walk ends (an empty queue is answered
// at once); no other request is accepted during the walk. A request is
// accepted whenever the block is not searching and the output register is
// empty or being drained in the same cycle. Pops on an empty queue and pushes
// on a full queue leave the state unchanged and report empty and full. The
// count in the response is the entry count after the operation, masked to the
// five bits of the field. There is no clearing pass after reset.
module bounded_deque_with_search_core #(
    parameter int DEPTH = dbq_pkg::DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  dbq_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output dbq_pkg::t_rsp o_out_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // control state
    dbq_pkg::t_state      r_state, n_state;
    logic [AW-1:0]        r_head, n_head;
    logic [CW-1:0]        r_count, n_count;
    logic                 r_out_vld, n_out_vld;
    dbq_pkg::t_rsp        r_out, n_out;

    // handshake and decode
    logic                 w_accept;
    logic                 w_full;
    logic                 w_empty;
    logic [CW:0]          w_tail_sum;
    logic [AW-1:0]        w_tail;
    logic [AW-1:0]        w_head_dec;
    logic [AW-1:0]        w_head_inc;

    // ram ports
    logic                          w_wr_en;
    logic [AW-1:0]                 w_wr_addr;
    logic                          w_rd_en;
    logic [AW-1:0]                 w_rd_addr;
    logic [dbq_pkg::VALUE_W-1:0]   w_rd_data;

    // search unit
    logic                 w_scan_start;
    dbq_pkg::t_scan_stat  w_scan_stat;

    assign o_in_ready = (r_state == dbq_pkg::S_IDLE) && (!r_out_vld || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_empty    = (r_count == '0);

    // slot behind the last entry, wrapped into the buffer
    assign w_tail_sum = (CW + 1)'(r_head) + (CW + 1)'(r_count);
    assign w_tail     = (w_tail_sum >= (CW + 1)'(DEPTH)) ?
                        AW'(w_tail_sum - (CW + 1)'(DEPTH)) : AW'(w_tail_sum);
    assign w_head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
    assign w_head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);

    assign w_scan_start = w_accept && (i_in_data.mode == dbq_pkg::MODE_CONTAINS) && !w_empty;

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_out_vld = r_out_vld && !i_out_ready;
        n_out     = r_out;
        w_wr_en   = 1'b0;
        w_wr_addr = w_tail;

        if (w_accept) begin
            n_out.found  = 1'b0;
            n_out.status = dbq_pkg::ST_OK;
            n_out_vld    = 1'b1;
            unique case (i_in_data.mode)
                dbq_pkg::MODE_PUSH_BACK: begin
                    if (w_full) begin
                        n_out.status = dbq_pkg::ST_FULL;
                    end else begin
                        w_wr_en = 1'b1;
                        n_count = r_count + CW'(1);
                    end
                end
                dbq_pkg::MODE_PUSH_FRONT: begin
                    if (w_full) begin
                        n_out.status = dbq_pkg::ST_FULL;
                    end else begin
                        // new front sits one slot below the old head
                        w_wr_en   = 1'b1;
                        w_wr_addr = w_head_dec;
                        n_head    = w_head_dec;
                        n_count   = r_count + CW'(1);
                    end
                end
                dbq_pkg::MODE_POP_FRONT: begin
                    if (w_empty) begin
                        n_out.status = dbq_pkg::ST_EMPTY;
                    end else begin
                        n_head  = w_head_inc;
                        n_count = r_count - CW'(1);
                    end
                end
                dbq_pkg::MODE_POP_BACK: begin
                    if (w_empty) begin
                        n_out.status = dbq_pkg::ST_EMPTY;
                    end else begin
                        n_count = r_count - CW'(1);
                    end
                end
                dbq_pkg::MODE_CONTAINS: begin
                    // a non-empty queue hands over to the search unit
                    if (!w_empty) begin
                        n_out_vld = 1'b0;
                        n_state   = dbq_pkg::S_SCAN;
                    end
                end
                default: begin
                    // unused codes change nothing
                end
            endcase
            n_out.count = dbq_pkg::CNT_W'(n_count);
        end

        if (r_state == dbq_pkg::S_SCAN && w_scan_stat.done) begin
            n_out.found  = w_scan_stat.found;
            n_out.status = dbq_pkg::ST_OK;
            n_out.count  = dbq_pkg::CNT_W'(r_count);
            n_out_vld    = 1'b1;
            n_state      = dbq_pkg::S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dbq_pkg::S_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
        end
        r_out <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // entry store
    dbq_ram #(
        .WIDTH (dbq_pkg::VALUE_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (i_in_data.value),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // membership walk from the head over the held entries
    dbq_scan #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_scan_start),
        .i_base    (r_head),
        .i_len     (r_count),
        .i_key     (i_in_data.value),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data),
        .o_stat    (w_scan_stat)
    );

    // no request taken while a search is running
    a_no_accept_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dbq_pkg::S_SCAN) |-> !o_in_ready)
        else $error("request accepted during search");

    // count never goes beyond the buffer depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    // the search unit only completes while the control waits for it
    a_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scan_stat.done |-> (r_state == dbq_pkg::S_SCAN))
        else $error("search done outside scan state");

    // a search never alters the queue
    a_scan_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dbq_pkg::S_SCAN) |=> ($stable(r_count) && $stable(r_head)))
        else $error("queue changed during search");

    // a started search leaves the output register empty until it finishes
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scan_start |=> (w_scan_stat.busy && !r_out_vld))
        else $error("search did not start cleanly");

endmodule

/* design/dbq_ram.sv */
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module dbq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/dbq_scan.sv */
// membership search unit: walks the held entries one ram read per cycle
// depends on dbq_pkg
`timescale 1ns / 1ps

module dbq_scan #(
    parameter int DEPTH = dbq_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [AW-1:0]                   i_base,
    input  logic [CW-1:0]                   i_len,
    input  logic [dbq_pkg::VALUE_W-1:0]     i_key,
    output logic                            o_rd_en,
    output logic [AW-1:0]                   o_rd_addr,
    input  logic [dbq_pkg::VALUE_W-1:0]     i_rd_data,
    output dbq_pkg::t_scan_stat             o_stat
);

    logic                        r_busy, n_busy;
    logic [AW-1:0]               r_addr, n_addr;
    logic [CW-1:0]               r_left, n_left;
    logic                        r_cmp_vld, n_cmp_vld;
    logic                        r_last, n_last;
    logic                        r_hit, n_hit;
    logic [dbq_pkg::VALUE_W-1:0] r_key;
    logic                        w_eq;

    assign w_eq      = r_cmp_vld && (i_rd_data == r_key);
    assign o_rd_en   = r_busy;
    assign o_rd_addr = r_addr;

    always_comb begin
        n_busy    = r_busy;
        n_addr    = r_addr;
        n_left    = r_left;
        n_cmp_vld = 1'b0;
        n_last    = 1'b0;
        n_hit     = r_hit | w_eq;
        if (i_start) begin
            n_busy = 1'b1;
            n_addr = i_base;
            n_left = i_len;
            n_hit  = 1'b0;
        end else if (r_busy) begin
            // issue one read, compare it next cycle
            n_addr    = (r_addr == AW'(DEPTH - 1)) ? '0 : r_addr + AW'(1);
            n_left    = r_left - CW'(1);
            n_cmp_vld = 1'b1;
            n_last    = (r_left == CW'(1));
            if (r_left == CW'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_last    <= 1'b0;
            r_hit     <= 1'b0;
        end else begin
            r_busy    <= n_busy;
            r_cmp_vld <= n_cmp_vld;
            r_last    <= n_last;
            r_hit     <= n_hit;
        end
        r_addr <= n_addr;
        r_left <= n_left;
        if (i_start) begin
            r_key <= i_key;
        end
    end

    assign o_stat.busy  = r_busy | r_cmp_vld;
    assign o_stat.done  = r_cmp_vld & r_last;
    assign o_stat.found = r_hit | w_eq;

endmodule

/* sim/bounded_deque_with_search_core_tb.sv */
// self-checking testbench for the bounded deque with membership search
// depends on dbq_pkg and bounded_deque_with_search_core; predicts every response itself
`timescale 1ns / 1ps

module bounded_deque_with_search_core_tb;

    import dbq_pkg::*;

    localparam int QUEUE_DEPTH = DEPTH_DEF;

    // mode codes the block has no operation for
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    // cycles without any handshake before the run is given up
    localparam int STUCK_LIMIT = 2000;
    // quiet cycles after the last response, well beyond the longest search
    localparam int TAIL_CYCLES = 40;
    // cap on printed mismatch lines, counting carries on regardless
    localparam int PRINT_CAP   = 200;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_req i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_rsp o_out_data;

    // model of the held entries, front at index 0
    logic signed [VALUE_W-1:0] held_q[$];
    // responses still owed by the block, oldest first
    t_rsp pending_rsp[$];

    int mismatch_cnt = 0;
    int rsp_seen     = 0;
    // odds (percent) of an idle burst, per request for the sender, per cycle for the receiver
    int gap_odds     = 10;
    int stall_odds   = 10;

    bounded_deque_with_search_core #(
        .DEPTH(QUEUE_DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // applies one request to the model queue and returns the response it owes
    function automatic t_rsp predict_outcome(input t_req r);
        t_rsp rsp;
        rsp        = '0;
        rsp.status = ST_OK;
        case (r.mode)
            MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
                // a push on a full queue is dropped
                if (held_q.size() >= QUEUE_DEPTH) begin
                    rsp.status = ST_FULL;
                end else if (r.mode == MODE_PUSH_BACK) begin
                    held_q.push_back(r.value);
                end else begin
                    held_q.push_front(r.value);
                end
            end
            MODE_POP_FRONT: begin
                if (held_q.size() == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    void'(held_q.pop_front());
                end
            end
            MODE_POP_BACK: begin
                if (held_q.size() == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    void'(held_q.pop_back());
                end
            end
            MODE_CONTAINS: begin
                // every held entry is compared, the back one included
                foreach (held_q[i]) begin
                    if (held_q[i] == r.value) begin
                        rsp.found = 1'b1;
                    end
                end
            end
            default: begin
                // spare codes change nothing
            end
        endcase
        rsp.count = CNT_W'(held_q.size());
        return rsp;
    endfunction

    // values biased towards the extremes and towards small numbers that repeat
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7FFF_FFFF;
                    2: return 32'sh0000_0000;
                    default: return -32'sd1;
                endcase
            end
            1: return $signed(VALUE_W'($urandom_range(0, 7))) - 32'sd4;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // presents one request from a falling edge, holds it until accepted, then
    // maybe idles; valid is left high when no gap follows
    task automatic send_req(input logic [MODE_W-1:0] mode,
                            input logic signed [VALUE_W-1:0] value);
        t_req r;
        r.mode     = mode;
        r.value    = value;
        i_in_valid = 1'b1;
        i_in_data  = r;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        pending_rsp.push_back(predict_outcome(r));
        @(negedge i_clk);
        if ($urandom_range(0, 99) < gap_odds) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
    endtask

    // stops sending and waits until every owed response has been taken
    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (pending_rsp.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------
    // response side
    // ------------------------------------------------------------------

    // ready drops in bursts of random length, changed at falling edges
    initial begin : rsp_sink
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 99) < stall_odds) begin
                i_out_ready = 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
        end
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_cnt < PRINT_CAP) begin
            $display("[%0t] response %0d: %s", $realtime, rsp_seen, msg);
        end
        mismatch_cnt++;
    endtask

    // each taken response is compared field by field with the oldest one owed
    always @(posedge i_clk) begin : rsp_checker
        t_rsp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_rsp.size() == 0) begin
                report_mismatch($sformatf("unexpected response found %0d status %0d count %0d",
                                          o_out_data.found, o_out_data.status,
                                          o_out_data.count));
            end else begin
                want = pending_rsp.pop_front();
                if (o_out_data.found !== want.found) begin
                    report_mismatch($sformatf("found %0b, expected %0b",
                                              o_out_data.found, want.found));
                end
                if (o_out_data.status !== want.status) begin
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_out_data.status, want.status));
                end
                if (o_out_data.count !== want.count) begin
                    report_mismatch($sformatf("count %0d, expected %0d",
                                              o_out_data.count, want.count));
                end
            end
            rsp_seen++;
        end
    end

    // run is abandoned when neither side has moved for too long
    initial begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                stuck = 0;
            end else begin
                stuck++;
            end
        end
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // pops and search on an empty queue, and a spare mode code
    task automatic test_empty_queue();
        send_req(MODE_POP_FRONT, 32'sh7FFF_FFFF);
        send_req(MODE_POP_BACK, 32'sh8000_0000);
        send_req(MODE_CONTAINS, 32'sh0000_0000);
        send_req(MODE_SPARE_HI, -32'sd1);
    endtask

    // fill from both ends with extreme values, push into a full queue from
    // both ends, then search for the front, the back and a missing value
    task automatic test_fill_to_full();
        int k;
        logic signed [VALUE_W-1:0] v;
        for (k = 0; k < QUEUE_DEPTH; k++) begin
            case (k)
                0: v = 32'sh8000_0000;
                1: v = 32'sh7FFF_FFFF;
                2: v = 32'sh0000_0000;
                3: v = -32'sd1;
                default: v = 32'sd100 + k;
            endcase
            send_req(k[0] ? MODE_PUSH_FRONT : MODE_PUSH_BACK, v);
        end
        send_req(MODE_PUSH_BACK, 32'sd55);
        send_req(MODE_PUSH_FRONT, 32'sd56);
        send_req(MODE_CONTAINS, held_q[0]);
        // the back entry is the one a naive search would skip
        send_req(MODE_CONTAINS, held_q[held_q.size() - 1]);
        send_req(MODE_CONTAINS, 32'sd99);
    endtask

    // sender holds off until all responses are in, then a search runs alone
    task automatic test_pause_until_drained();
        wait_drained();
        send_req(MODE_CONTAINS, (held_q.size() != 0) ? held_q[0] : 32'sd1);
        send_req(MODE_POP_FRONT, 32'sd0);
    endtask

    // random operations in fill and drain sweeps so that full and empty are
    // reached again and again, with searches that both hit and miss
    task automatic test_random_ops(input int n_items, input int in_gaps,
                                   input int out_stalls);
        int k;
        int roll;
        bit filling;
        logic [MODE_W-1:0] mode;
        logic signed [VALUE_W-1:0] value;
        gap_odds   = in_gaps;
        stall_odds = out_stalls;
        filling    = 1'b1;
        for (k = 0; k < n_items; k++) begin
            // turn the sweep round after lingering a while at full or empty
            if (filling && held_q.size() == QUEUE_DEPTH && $urandom_range(0, 3) == 0) begin
                filling = 1'b0;
            end else if (!filling && held_q.size() == 0 && $urandom_range(0, 3) == 0) begin
                filling = 1'b1;
            end
            roll  = $urandom_range(0, 99);
            value = pick_value();
            if (roll < (filling ? 62 : 22)) begin
                mode = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
            end else if (roll < 84) begin
                mode = $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
            end else if (roll < 97) begin
                mode = MODE_CONTAINS;
                // mostly look for something that is held, anywhere in the queue
                if (held_q.size() != 0 && $urandom_range(0, 2) != 0) begin
                    value = held_q[$urandom_range(0, held_q.size() - 1)];
                end
            end else begin
                mode = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
            end
            send_req(mode, value);
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin : main_seq
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_queue();
        test_fill_to_full();
        test_random_ops(360, 20, 20);
        test_pause_until_drained();
        // sender idles a lot, receiver never stalls
        test_random_ops(360, 40, 0);
        // receiver stalls a lot, sender never idles
        test_random_ops(360, 0, 40);
        // last stretch at full rate on both sides
        test_random_ops(360, 0, 0);

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (mismatch_cnt == 0 && pending_rsp.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
